// ===== design/mpgc_pkg.sv =====
// Package: types, constants and helper functions for the match pair geometry unit.
package mpgc_pkg;

   localparam int NUM_CELLS = 16;
   localparam int LOG_FRAC  = 16;
   localparam int XW        = 38;
   localparam int ZW        = 35;

   localparam logic [16:0]          TWO_PI_F     = 17'd25736;
   localparam logic signed [14:0]   PI_F         = 15'sd12868;
   localparam logic signed [ZW-1:0] PI_Q30       = 35'sd3373259426;
   localparam logic signed [29:0]   LN2_HALF_Q30 = 30'sd372130559;

   typedef struct packed {
      logic [15:0]        a_x_first;
      logic [15:0]        a_y_first;
      logic [15:0]        a_x_second;
      logic [15:0]        a_y_second;
      logic signed [15:0] a_rel_angle;
      logic signed [15:0] a_rel_logscale;
      logic [15:0]        b_x_first;
      logic [15:0]        b_y_first;
      logic [15:0]        b_x_second;
      logic [15:0]        b_y_second;
      logic signed [15:0] b_rel_angle;
      logic signed [15:0] b_rel_logscale;
   } mpgc_req_type;

   typedef struct packed {
      logic [13:0] orient_gap;
      logic [15:0] scale_gap;
      logic [13:0] inter_orient_gap;
      logic [15:0] inter_scale_gap;
      logic        degenerate;
   } mpgc_rsp_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [31:0]          m1;
      logic [31:0]          m2;
      logic [15:0]          f1;
      logic [15:0]          f2;
      logic [5:0]           msb1;
      logic [5:0]           msb2;
      logic signed [15:0]   aang;
      logic signed [15:0]   ascl;
      logic [13:0]          orient;
      logic [15:0]          scale;
      logic                 degen;
   } mpgc_cell_type;

   function automatic logic [30:0] atan_q30(input int i);
      case (i)
         0:  atan_q30 = 31'h3243F6A8;
         1:  atan_q30 = 31'h1DAC6705;
         2:  atan_q30 = 31'h0FADBAFC;
         3:  atan_q30 = 31'h07F56EA6;
         4:  atan_q30 = 31'h03FEAB76;
         5:  atan_q30 = 31'h01FFD55B;
         6:  atan_q30 = 31'h00FFFAAA;
         7:  atan_q30 = 31'h007FFF55;
         8:  atan_q30 = 31'h003FFFEA;
         9:  atan_q30 = 31'h001FFFFD;
         10: atan_q30 = 31'h000FFFFF;
         11: atan_q30 = 31'h0007FFFF;
         12: atan_q30 = 31'h0003FFFF;
         13: atan_q30 = 31'h0001FFFF;
         14: atan_q30 = 31'h0000FFFF;
         15: atan_q30 = 31'h00007FFF;
         16: atan_q30 = 31'h00003FFF;
         17: atan_q30 = 31'h00001FFF;
         18: atan_q30 = 31'h00000FFF;
         19: atan_q30 = 31'h000007FF;
         20: atan_q30 = 31'h000003FF;
         21: atan_q30 = 31'h000001FF;
         22: atan_q30 = 31'h000000FF;
         default: atan_q30 = 31'h0000007F;
      endcase
   endfunction

   // |x-y| wrapped by 2pi and folded into 0..pi
   function automatic logic [13:0] fold(input logic [16:0] d);
      logic [16:0] a;
      logic [16:0] b;
      logic [16:0] t;
      a = (d > TWO_PI_F) ? d - TWO_PI_F : d;
      b = (a > TWO_PI_F) ? a - TWO_PI_F : a;
      t = TWO_PI_F - b;
      fold = (b < t) ? b[13:0] : t[13:0];
   endfunction

endpackage

// ===== design/mpgc_ifs.sv =====
// Interfaces: request and response channels of the match pair geometry unit.
interface mpgc_req_if;
   logic                  valid;
   logic                  ready;
   mpgc_pkg::mpgc_req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mpgc_rsp_if;
   logic                  valid;
   logic                  ready;
   mpgc_pkg::mpgc_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/mpgc_front.sv =====
// Front stages: displacement vectors, products, sums, CORDIC pre-rotation, log normalize.
module mpgc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  mpgc_pkg::mpgc_req_type  req_data,
   output logic                    out_valid,
   output mpgc_pkg::mpgc_cell_type out_cell
);
   import mpgc_pkg::*;

   function automatic logic [5:0] msb_of(input logic [33:0] v);
      logic [5:0] r;
      r = 6'd0;
      for (int i = 1; i < 34; i++) begin
         if (v[i]) begin
            r = 6'(i);
         end
      end
      msb_of = r;
   endfunction

   logic [4:0] vld_ff;

   // stage A
   logic signed [16:0] ux_in, uy_in, wx_in, wy_in;
   logic signed [16:0] ux_ff, uy_ff, wx_ff, wy_ff;
   logic signed [16:0] ad_in, sd_in;
   logic [16:0]        ad_ff;
   logic [15:0]        sd_ff;
   logic               dg_a_ff;
   logic signed [15:0] aang_a_ff, ascl_a_ff;

   // stage B
   logic signed [33:0] p_uxwy_ff, p_uywx_ff, p_uxwx_ff, p_uywy_ff;
   logic [33:0]        s_ux_ff, s_uy_ff, s_wx_ff, s_wy_ff;
   logic [13:0]        or_b_ff;
   logic [15:0]        sd_b_ff;
   logic               dg_b_ff;
   logic signed [15:0] aang_b_ff, ascl_b_ff;

   // stage C
   logic signed [35:0] cross_ff, dot_ff;
   logic [33:0]        n1_ff, n2_ff;
   logic [13:0]        or_c_ff;
   logic [15:0]        sd_c_ff;
   logic               dg_c_ff;
   logic signed [15:0] aang_c_ff, ascl_c_ff;

   // stage D
   logic signed [XW-1:0] x_d_in, y_d_in, x_d_ff, y_d_ff;
   logic signed [ZW-1:0] z_d_in, z_d_ff;
   logic [33:0]        n1_d_ff, n2_d_ff;
   logic [5:0]         msb1_d_ff, msb2_d_ff;
   logic [13:0]        or_d_ff;
   logic [15:0]        sd_d_ff;
   logic               dg_d_ff;
   logic signed [15:0] aang_d_ff, ascl_d_ff;

   // stage E
   mpgc_cell_type cell_in, cell_ff;
   logic [65:0]   sh1, sh2;

   always_comb begin
      ux_in = {1'b0, req_data.a_x_first}  - {1'b0, req_data.b_x_first};
      uy_in = {1'b0, req_data.a_y_first}  - {1'b0, req_data.b_y_first};
      wx_in = {1'b0, req_data.a_x_second} - {1'b0, req_data.b_x_second};
      wy_in = {1'b0, req_data.a_y_second} - {1'b0, req_data.b_y_second};
      ad_in = {req_data.a_rel_angle[15], req_data.a_rel_angle}
            - {req_data.b_rel_angle[15], req_data.b_rel_angle};
      sd_in = {req_data.a_rel_logscale[15], req_data.a_rel_logscale}
            - {req_data.b_rel_logscale[15], req_data.b_rel_logscale};
   end

   always_comb begin
      if (dot_ff < 0) begin
         x_d_in = XW'(-dot_ff);
         y_d_in = XW'(-cross_ff);
         z_d_in = (cross_ff >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
         x_d_in = XW'(dot_ff);
         y_d_in = XW'(cross_ff);
         z_d_in = '0;
      end
   end

   always_comb begin
      sh1 = (msb1_d_ff <= 6'd31) ? ({32'd0, n1_d_ff} << (6'd31 - msb1_d_ff))
                                 : ({32'd0, n1_d_ff} >> (msb1_d_ff - 6'd31));
      sh2 = (msb2_d_ff <= 6'd31) ? ({32'd0, n2_d_ff} << (6'd31 - msb2_d_ff))
                                 : ({32'd0, n2_d_ff} >> (msb2_d_ff - 6'd31));
      cell_in.x      = x_d_ff;
      cell_in.y      = y_d_ff;
      cell_in.z      = z_d_ff;
      cell_in.m1     = sh1[31:0];
      cell_in.m2     = sh2[31:0];
      cell_in.f1     = '0;
      cell_in.f2     = '0;
      cell_in.msb1   = msb1_d_ff;
      cell_in.msb2   = msb2_d_ff;
      cell_in.aang   = aang_d_ff;
      cell_in.ascl   = ascl_d_ff;
      cell_in.orient = or_d_ff;
      cell_in.scale  = sd_d_ff;
      cell_in.degen  = dg_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ff     <= ux_in;
         uy_ff     <= uy_in;
         wx_ff     <= wx_in;
         wy_ff     <= wy_in;
         ad_ff     <= ad_in[16] ? 17'(-ad_in) : 17'(ad_in);
         sd_ff     <= sd_in[16] ? 16'(-sd_in) : sd_in[15:0];
         dg_a_ff   <= (ux_in == 0 && uy_in == 0) || (wx_in == 0 && wy_in == 0);
         aang_a_ff <= req_data.a_rel_angle;
         ascl_a_ff <= req_data.a_rel_logscale;

         p_uxwy_ff <= ux_ff * wy_ff;
         p_uywx_ff <= uy_ff * wx_ff;
         p_uxwx_ff <= ux_ff * wx_ff;
         p_uywy_ff <= uy_ff * wy_ff;
         s_ux_ff   <= 34'(ux_ff * ux_ff);
         s_uy_ff   <= 34'(uy_ff * uy_ff);
         s_wx_ff   <= 34'(wx_ff * wx_ff);
         s_wy_ff   <= 34'(wy_ff * wy_ff);
         or_b_ff   <= fold(ad_ff);
         sd_b_ff   <= sd_ff;
         dg_b_ff   <= dg_a_ff;
         aang_b_ff <= aang_a_ff;
         ascl_b_ff <= ascl_a_ff;

         cross_ff  <= 36'(p_uxwy_ff) - 36'(p_uywx_ff);
         dot_ff    <= 36'(p_uxwx_ff) + 36'(p_uywy_ff);
         n1_ff     <= s_ux_ff + s_uy_ff;
         n2_ff     <= s_wx_ff + s_wy_ff;
         or_c_ff   <= or_b_ff;
         sd_c_ff   <= sd_b_ff;
         dg_c_ff   <= dg_b_ff;
         aang_c_ff <= aang_b_ff;
         ascl_c_ff <= ascl_b_ff;

         x_d_ff    <= x_d_in;
         y_d_ff    <= y_d_in;
         z_d_ff    <= z_d_in;
         n1_d_ff   <= n1_ff;
         n2_d_ff   <= n2_ff;
         msb1_d_ff <= msb_of(n1_ff);
         msb2_d_ff <= msb_of(n2_ff);
         or_d_ff   <= or_c_ff;
         sd_d_ff   <= sd_c_ff;
         dg_d_ff   <= dg_c_ff;
         aang_d_ff <= aang_c_ff;
         ascl_d_ff <= ascl_c_ff;

         cell_ff   <= cell_in;
      end
   end

   assign out_valid = vld_ff[4];
   assign out_cell  = cell_ff;
endmodule

// ===== design/mpgc_cell.sv =====
// Cell: one CORDIC vectoring iteration and one log2 squaring step for both lengths.
module mpgc_cell #(
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  mpgc_pkg::mpgc_cell_type in_cell,
   output logic                    out_valid,
   output mpgc_pkg::mpgc_cell_type out_cell
);
   import mpgc_pkg::*;

   localparam int FBIT = LOG_FRAC - 1 - STAGE;
   localparam logic signed [ZW-1:0] ATAN = $signed({4'b0000, atan_q30(STAGE)});

   mpgc_cell_type cell_in, cell_ff;
   logic          vld_ff;
   logic [63:0]   sq1, sq2;
   logic [32:0]   t1, t2;

   always_comb begin
      cell_in = in_cell;
      if (in_cell.y < 0) begin
         cell_in.x = in_cell.x - (in_cell.y >>> STAGE);
         cell_in.y = in_cell.y + (in_cell.x >>> STAGE);
         cell_in.z = in_cell.z - ATAN;
      end else begin
         cell_in.x = in_cell.x + (in_cell.y >>> STAGE);
         cell_in.y = in_cell.y - (in_cell.x >>> STAGE);
         cell_in.z = in_cell.z + ATAN;
      end
      sq1 = in_cell.m1 * in_cell.m1;
      sq2 = in_cell.m2 * in_cell.m2;
      t1  = sq1[63:31];
      t2  = sq2[63:31];
      if (t1[32]) begin
         cell_in.m1       = t1[32:1];
         cell_in.f1[FBIT] = 1'b1;
      end else begin
         cell_in.m1 = t1[31:0];
      end
      if (t2[32]) begin
         cell_in.m2       = t2[32:1];
         cell_in.f2[FBIT] = 1'b1;
      end else begin
         cell_in.m2 = t2[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_cell  = cell_ff;
endmodule

// ===== design/mpgc_back.sv =====
// Back stages: angle rounding and clamp, log ratio scaling, folding, saturation, output register.
module mpgc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  mpgc_pkg::mpgc_cell_type in_cell,
   output logic                    out_valid,
   output mpgc_pkg::mpgc_rsp_type  out_data
);
   import mpgc_pkg::*;

   localparam logic signed [ZW-1:0] Z_RND = ZW'(1) <<< 17;
   localparam logic signed [52:0]   P_RND = 53'(1) <<< 33;

   logic [2:0] vld_ff;

   logic [21:0]          res1, res2;
   logic signed [22:0]   d_in;
   logic signed [ZW-1:0] zr;
   logic signed [16:0]   zq;
   logic signed [14:0]   ang_in, ang_ff;
   logic signed [52:0]   prod_ff;
   logic [13:0]          or_1_ff, or_2_ff;
   logic [15:0]          sd_1_ff, sd_2_ff;
   logic                 dg_1_ff, dg_2_ff;
   logic signed [15:0]   aang_1_ff, ascl_1_ff;

   logic signed [52:0]   pr;
   logic signed [18:0]   rs;
   logic signed [16:0]   ida_in;
   logic [16:0]          ida_ff;
   logic signed [19:0]   isc_ff;
   logic [19:0]          isc_abs;

   mpgc_rsp_type rsp_in, rsp_ff;

   always_comb begin
      res1   = {in_cell.msb1, in_cell.f1};
      res2   = {in_cell.msb2, in_cell.f2};
      d_in   = $signed({1'b0, res1}) - $signed({1'b0, res2});
      zr     = in_cell.z + Z_RND;
      zq     = zr[ZW-1:18];
      if (zq > 17'(PI_F)) begin
         ang_in = PI_F;
      end else if (zq < -17'(PI_F)) begin
         ang_in = -PI_F;
      end else begin
         ang_in = zq[14:0];
      end
   end

   always_comb begin
      pr     = prod_ff + P_RND;
      rs     = pr[52:34];
      ida_in = {aang_1_ff[15], aang_1_ff} - 17'(ang_ff);
   end

   always_comb begin
      isc_abs = isc_ff[19] ? 20'(-isc_ff) : 20'(isc_ff);
      rsp_in.orient_gap       = or_2_ff;
      rsp_in.scale_gap        = sd_2_ff;
      rsp_in.degenerate       = dg_2_ff;
      if (dg_2_ff) begin
         rsp_in.inter_orient_gap = '0;
         rsp_in.inter_scale_gap  = '0;
      end else begin
         rsp_in.inter_orient_gap = fold(ida_ff);
         rsp_in.inter_scale_gap  = (isc_abs > 20'd65535) ? 16'hFFFF : isc_abs[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff    <= ang_in;
         prod_ff   <= d_in * LN2_HALF_Q30;
         or_1_ff   <= in_cell.orient;
         sd_1_ff   <= in_cell.scale;
         dg_1_ff   <= in_cell.degen;
         aang_1_ff <= in_cell.aang;
         ascl_1_ff <= in_cell.ascl;

         ida_ff    <= ida_in[16] ? 17'(-ida_in) : 17'(ida_in);
         isc_ff    <= 20'(ascl_1_ff) - 20'(rs);
         or_2_ff   <= or_1_ff;
         sd_2_ff   <= sd_1_ff;
         dg_2_ff   <= dg_1_ff;

         rsp_ff    <= rsp_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_data  = rsp_ff;
endmodule

// ===== design/match_pair_geometry_consistency_unit.sv =====
// Top level: match pair geometry consistency pipeline built from a chain of CORDIC/log cells.
//
//   channel | dir | handshake   | payload
//   req     | in  | valid/ready | mpgc_req_type, two match pairs
//   rsp     | out | valid/ready | mpgc_rsp_type, four gaps and degenerate flag
//
// One transaction per cycle while the output is not stalled; 5 front stages, 16 cells, 3 back stages.
// The chain of 16 cells, one CORDIC iteration and one log2 squaring step each, lies between front and back.
// Reset clears only the valid bits of every stage.
// When a result waits and rsp is not ready, the whole pipeline holds and req.ready drops.
module match_pair_geometry_consistency_unit (
   input logic      clock,
   input logic      reset,
   mpgc_req_if.sink   req,
   mpgc_rsp_if.source rsp
);
   import mpgc_pkg::*;

   logic          en;
   logic          vld_bus  [NUM_CELLS+1];
   mpgc_cell_type cell_bus [NUM_CELLS+1];

   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   mpgc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req.valid),
      .req_data  (req.data),
      .out_valid (vld_bus[0]),
      .out_cell  (cell_bus[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      mpgc_cell #(.STAGE(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld_bus[i]),
         .in_cell   (cell_bus[i]),
         .out_valid (vld_bus[i+1]),
         .out_cell  (cell_bus[i+1])
      );
   end

   mpgc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_bus[NUM_CELLS]),
      .in_cell   (cell_bus[NUM_CELLS]),
      .out_valid (rsp.valid),
      .out_data  (rsp.data)
   );
endmodule

// ===== tb/match_pair_geometry_consistency_unit_tb.sv =====
// Testbench: match pair geometry unit checked against a predictor, random stalls on both sides.
module match_pair_geometry_consistency_unit_tb;
   import mpgc_pkg::*;

   logic clock;
   logic reset;
   mpgc_req_if req_ch ();
   mpgc_rsp_if rsp_ch ();

   match_pair_geometry_consistency_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   mpgc_rsp_type expected_gaps[$];
   int           error_count;
   bit           no_stall;
   int           rsp_hold;

   longint atan_tab[16] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   function automatic longint q30_to_frac(longint q);
      return (q + (64'sd1 <<< 17)) >>> 18;
   endfunction

   function automatic longint wrap_angle(longint x, longint y);
      longint two_pi;
      longint d;
      longint t;
      two_pi = q30_to_frac(64'sd6746518852);
      d = x - y;
      if (d < 0) d = -d;
      while (d > two_pi) d -= two_pi;
      t = two_pi - d;
      return (d < t) ? d : t;
   endfunction

   function automatic longint clip_abs(longint v, longint maxv);
      if (v < 0) v = -v;
      return (v > maxv) ? maxv : v;
   endfunction

   function automatic longint vector_angle(longint dot, longint cross_v);
      longint x;
      longint y;
      longint z;
      longint nx;
      longint pi_f;
      longint r;
      x = dot;
      y = cross_v;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = (cross_v >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      end
      for (int i = 0; i < 16; i++) begin
         if (y < 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_tab[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_tab[i];
         end
         x = nx;
      end
      pi_f = q30_to_frac(64'sd3373259426);
      r = q30_to_frac(z);
      if (r > pi_f) r = pi_f;
      if (r < -pi_f) r = -pi_f;
      return r;
   endfunction

   function automatic longint log2_q16(longint unsigned v);
      int unsigned msb;
      longint unsigned m;
      longint res;
      msb = 0;
      while (msb < 63 && (v >> (msb + 1)) != 0) msb++;
      m = (msb <= 31) ? (v << (31 - msb)) : (v >> (msb - 31));
      res = longint'(msb) <<< 16;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m >>= 1;
            res |= 64'sd1 <<< (15 - k);
         end
      end
      return res;
   endfunction

   function automatic mpgc_rsp_type predict_gaps(mpgc_req_type r);
      mpgc_rsp_type o;
      longint ux;
      longint uy;
      longint wx;
      longint wy;
      longint cross_v;
      longint dot;
      longint ang;
      longint d;
      longint rs;
      longint aang;
      longint ascl;
      ux = longint'(r.a_x_first) - longint'(r.b_x_first);
      uy = longint'(r.a_y_first) - longint'(r.b_y_first);
      wx = longint'(r.a_x_second) - longint'(r.b_x_second);
      wy = longint'(r.a_y_second) - longint'(r.b_y_second);
      aang = longint'(r.a_rel_angle);
      ascl = longint'(r.a_rel_logscale);
      o.degenerate = (ux == 0 && uy == 0) || (wx == 0 && wy == 0);
      o.inter_orient_gap = '0;
      o.inter_scale_gap = '0;
      if (!o.degenerate) begin
         cross_v = ux * wy - uy * wx;
         dot = ux * wx + uy * wy;
         ang = vector_angle(dot, cross_v);
         d = log2_q16(ux * ux + uy * uy) - log2_q16(wx * wx + wy * wy);
         rs = (d * 64'sd372130559 + (64'sd1 <<< 33)) >>> 34;
         o.inter_orient_gap = 14'(clip_abs(wrap_angle(aang, ang), 16383));
         o.inter_scale_gap = 16'(clip_abs(ascl - rs, 65535));
      end
      o.orient_gap = 14'(clip_abs(wrap_angle(aang, longint'(r.b_rel_angle)), 16383));
      o.scale_gap = 16'(clip_abs(ascl - longint'(r.b_rel_logscale), 65535));
      return o;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      error_count++;
   endtask

   task automatic send_pair(mpgc_req_type item);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.data <= item;
      do @(posedge clock); while (!req_ch.ready);
      expected_gaps.push_back(predict_gaps(item));
      gap = no_stall ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic mpgc_req_type rand_pair(int span);
      mpgc_req_type r;
      r = mpgc_req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      if (span < 65535) begin
         r.b_x_first = r.a_x_first + 16'($urandom_range(0, span));
         r.b_y_first = r.a_y_first + 16'($urandom_range(0, span));
         r.b_x_second = r.a_x_second + 16'($urandom_range(0, span));
         r.b_y_second = r.a_y_second + 16'($urandom_range(0, span));
      end
      return r;
   endfunction

   task automatic test_extremes();
      mpgc_req_type r;
      r = '0;
      send_pair(r);
      r = '1;
      send_pair(r);
      r = '0;
      r.a_rel_angle = 16'sh7FFF;
      r.b_rel_angle = 16'sh8000;
      r.a_rel_logscale = 16'sh7FFF;
      r.b_rel_logscale = 16'sh8000;
      r.a_x_first = 16'hFFFF;
      r.b_y_second = 16'hFFFF;
      send_pair(r);
      r.a_rel_angle = 16'sh8000;
      r.b_rel_angle = 16'sh7FFF;
      r.a_rel_logscale = 16'sh8000;
      r.b_rel_logscale = 16'sh7FFF;
      r.a_y_first = 16'hFFFF;
      r.a_x_second = 16'hFFFF;
      send_pair(r);
      r = '0;
      r.a_rel_angle = 16'sd12868;
      r.b_rel_angle = -16'sd12868;
      r.a_x_first = 16'd1;
      r.a_y_second = 16'd1;
      send_pair(r);
   endtask

   task automatic test_vector_cases();
      mpgc_req_type r;
      r = '0;
      r.a_x_first = 16'd100;
      r.b_x_second = 16'd100;
      send_pair(r);
      r = '0;
      r.b_x_first = 16'd100;
      r.a_x_second = 16'd50;
      r.a_y_second = 16'd7;
      send_pair(r);
      r.a_y_second = 16'd0;
      r.b_y_second = 16'd7;
      send_pair(r);
      r = '0;
      r.a_x_first = 16'd5;
      r.a_y_second = 16'd9;
      send_pair(r);
      r = '0;
      r.a_x_first = 16'd3;
      r.a_x_second = 16'hFFFF;
      r.a_rel_logscale = 16'sh7FFF;
      send_pair(r);
      r = '0;
      r.a_x_first = 16'hFFFF;
      r.a_y_first = 16'hFFFF;
      r.a_x_second = 16'd1;
      r.a_rel_logscale = 16'sh8000;
      send_pair(r);
      r = '0;
      r.a_x_first = 16'd10;
      r.b_x_first = 16'd10;
      r.a_x_second = 16'd4;
      send_pair(r);
      r = '0;
      r.a_y_first = 16'd8;
      send_pair(r);
   endtask

   task automatic test_random(int count);
      int sel;
      for (int n = 0; n < count; n++) begin
         no_stall = (n % 200) < 30;
         sel = $urandom_range(0, 9);
         if (sel < 5) send_pair(rand_pair(255));
         else if (sel < 7) send_pair(rand_pair(65535));
         else if (sel < 9) send_pair(rand_pair(3));
         else send_pair(rand_pair(0));
      end
      no_stall = 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= 0;
      end else if (no_stall) begin
         rsp_ch.ready <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 59) == 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= $urandom_range(10, 40);
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 29) == 0) ? 1'b0 :
                         ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      mpgc_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_gaps.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = expected_gaps.pop_front();
            if (rsp_ch.data.orient_gap !== want.orient_gap)
               report_mismatch("orient_gap", rsp_ch.data.orient_gap, want.orient_gap);
            if (rsp_ch.data.scale_gap !== want.scale_gap)
               report_mismatch("scale_gap", rsp_ch.data.scale_gap, want.scale_gap);
            if (rsp_ch.data.inter_orient_gap !== want.inter_orient_gap)
               report_mismatch("inter_orient_gap", rsp_ch.data.inter_orient_gap,
                               want.inter_orient_gap);
            if (rsp_ch.data.inter_scale_gap !== want.inter_scale_gap)
               report_mismatch("inter_scale_gap", rsp_ch.data.inter_scale_gap,
                               want.inter_scale_gap);
            if (rsp_ch.data.degenerate !== want.degenerate)
               report_mismatch("degenerate", rsp_ch.data.degenerate, want.degenerate);
         end
      end
   end

   initial begin
      error_count = 0;
      no_stall = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_vector_cases();
      test_random(800);
      req_ch.valid <= 1'b0;
      while (expected_gaps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_gaps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mpgc_pkg.sv
design/mpgc_ifs.sv
design/mpgc_front.sv
design/mpgc_cell.sv
design/mpgc_back.sv
design/match_pair_geometry_consistency_unit.sv
tb/match_pair_geometry_consistency_unit_tb.sv
